FILE: sv/tpct_pkg.sv
// ----------------------------------------------------------------------------
// tpct_pkg
// Shared types and constants of the tag presence change tracker: payload
// layouts and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tpct_pkg;

   localparam int ANT_FIELD_BITS = 2;
   localparam int TAG_FIELD_BITS = 64;

   typedef struct packed {
      logic [ANT_FIELD_BITS-1:0] antenna;
      logic                      has_tag;
      logic [TAG_FIELD_BITS-1:0] tag;
      logic                      end_of_scan;
   } req_payload_type;

   typedef struct packed {
      logic [ANT_FIELD_BITS-1:0] antenna_out;
      logic [TAG_FIELD_BITS-1:0] tag_out;
      logic                      event_res;
      logic                      overflow;
      logic                      last;
   } rsp_payload_type;

   localparam logic EVENT_ENTER = 1'b0;
   localparam logic EVENT_LEAVE = 1'b1;

   typedef struct packed {
      logic load;
      logic store;
      logic search;
      logic emit_enter;
      logic leave_skip;
      logic leave_read;
      logic emit_leave;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic drop;
      logic has_tag;
      logic end_of_scan;
      logic search_done;
      logic found;
      logic out_free;
      logic leave_done;
      logic leave_seen;
   } status_type;

endpackage

FILE: sv/tpct_req_if.sv
// ----------------------------------------------------------------------------
// tpct_req_if
// Report channel: valid/ready handshake carrying one tag report.
// ----------------------------------------------------------------------------
interface tpct_req_if;
   logic                                valid;
   logic                                ready;
   logic [tpct_pkg::ANT_FIELD_BITS-1:0] antenna;
   logic                                has_tag;
   logic [tpct_pkg::TAG_FIELD_BITS-1:0] tag;
   logic                                end_of_scan;

   modport source (output valid, output antenna, output has_tag, output tag,
                   output end_of_scan, input ready);
   modport sink   (input valid, input antenna, input has_tag, input tag,
                   input end_of_scan, output ready);
endinterface

FILE: sv/tpct_rsp_if.sv
// ----------------------------------------------------------------------------
// tpct_rsp_if
// Event channel: valid/ready handshake carrying one enter or leave event.
// ----------------------------------------------------------------------------
interface tpct_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [tpct_pkg::ANT_FIELD_BITS-1:0] antenna_out;
   logic [tpct_pkg::TAG_FIELD_BITS-1:0] tag_out;
   logic                                event_res;
   logic                                overflow;
   logic                                last;

   modport source (output valid, output antenna_out, output tag_out,
                   output event_res, output overflow, output last, input ready);
   modport sink   (input valid, input antenna_out, input tag_out,
                   input event_res, input overflow, input last, output ready);
endinterface

FILE: sv/tag_presence_change_tracker.sv
// ----------------------------------------------------------------------------
// tag_presence_change_tracker
// Reports which tags entered or left each antenna's field between scans.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one tag report per transaction (antenna, has_tag, tag,
//   end_of_scan); rsp_bus carries enter and leave events, with last set on
//   the final event caused by a report.
//   One report at a time: req_bus.ready is high only while the block is idle.
//   A report that names no configured antenna, or has neither tag nor end
//   marker, is still taken and gives no event.
//   A tag report is searched for in that antenna's previous scan, which
//   holds MAX_TAGS entries at most, through the tag RAM at one entry per
//   cycle on its single read port. The enter event, if any, is registered
//   once the search has ended and the event register is free.
//   An end marker then walks the previous scan, skipping each seen tag,
//   emitting a leave event for each unseen one, and finally swaps the banks.
//   rsp_bus is held in an output register; a stalled receiver holds the
//   event and the block waits before producing the next one.
//   Reset empties every antenna's scan sets; the tag RAM needs no clearing.
// ----------------------------------------------------------------------------
module tag_presence_change_tracker #(
   parameter int NUM_ANTENNAS = 4,
   parameter int MAX_TAGS     = 32,
   parameter int TAG_BITS     = 64
) (
   input  logic              clock,
   input  logic              reset,
   tpct_req_if.sink          req_bus,
   tpct_rsp_if.source        rsp_bus
);

   tpct_pkg::req_payload_type req_data;
   tpct_pkg::rsp_payload_type rsp_data;
   tpct_pkg::cmd_type         cmd;
   tpct_pkg::status_type      status;
   logic                      req_ready;
   logic                      rsp_valid;

   assign req_data.antenna     = req_bus.antenna;
   assign req_data.has_tag     = req_bus.has_tag;
   assign req_data.tag         = req_bus.tag;
   assign req_data.end_of_scan = req_bus.end_of_scan;
   assign req_bus.ready        = req_ready;

   assign rsp_bus.valid        = rsp_valid;
   assign rsp_bus.antenna_out  = rsp_data.antenna_out;
   assign rsp_bus.tag_out      = rsp_data.tag_out;
   assign rsp_bus.event_res    = rsp_data.event_res;
   assign rsp_bus.overflow     = rsp_data.overflow;
   assign rsp_bus.last         = rsp_data.last;

   tpct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tpct_dp #(
      .NUM_ANTENNAS (NUM_ANTENNAS),
      .MAX_TAGS     (MAX_TAGS),
      .TAG_BITS     (TAG_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sv/tpct_ram.sv
// ----------------------------------------------------------------------------
// tpct_ram
// Generic simple dual-port RAM: one write port, one registered read port
// with read enable. Contents are undefined until written.
// ----------------------------------------------------------------------------
module tpct_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/tpct_ctrl.sv
// ----------------------------------------------------------------------------
// tpct_ctrl
// Sequencer of the tracker: takes a report, stores it, runs the search,
// emits the enter event, then walks the previous scan for leave events.
// ----------------------------------------------------------------------------
module tpct_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tpct_pkg::status_type status,
   output tpct_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_STORE      = 3'd1;
   localparam logic [2:0] ST_SEARCH     = 3'd2;
   localparam logic [2:0] ST_ENTER      = 3'd3;
   localparam logic [2:0] ST_LEAVE      = 3'd4;
   localparam logic [2:0] ST_LEAVE_EMIT = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !status.drop) begin
               cmd.load = 1'b1;
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = status.has_tag ? ST_SEARCH : ST_LEAVE;
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            if (status.search_done) begin
               if (!status.found) begin
                  state_in = ST_ENTER;
               end else begin
                  state_in = status.end_of_scan ? ST_LEAVE : ST_IDLE;
               end
            end
         end
         ST_ENTER: begin
            if (status.out_free) begin
               cmd.emit_enter = 1'b1;
               state_in       = status.end_of_scan ? ST_LEAVE : ST_IDLE;
            end
         end
         ST_LEAVE: begin
            priority if (status.leave_done) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.leave_seen) begin
               cmd.leave_skip = 1'b1;
            end else begin
               cmd.leave_read = 1'b1;
               state_in       = ST_LEAVE_EMIT;
            end
         end
         ST_LEAVE_EMIT: begin
            if (status.out_free) begin
               cmd.emit_leave = 1'b1;
               state_in       = ST_LEAVE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/tpct_dp.sv
// ----------------------------------------------------------------------------
// tpct_dp
// Datapath of the tracker: report registers, per-antenna bank and count
// state, seen marks, tag RAM with its search pipeline, and the event register.
// ----------------------------------------------------------------------------
module tpct_dp #(
   parameter int NUM_ANTENNAS = 4,
   parameter int MAX_TAGS     = 32,
   parameter int TAG_BITS     = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tpct_pkg::req_payload_type req_data,
   input  tpct_pkg::cmd_type         cmd,
   output tpct_pkg::status_type      status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output tpct_pkg::rsp_payload_type rsp_data
);

   localparam int AW    = (NUM_ANTENNAS > 1) ? $clog2(NUM_ANTENNAS) : 1;
   localparam int CW    = $clog2(MAX_TAGS + 1);
   localparam int IW    = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
   localparam int RAW   = AW + 1 + IW;
   localparam int DEPTH = 1 << RAW;

   logic [tpct_pkg::ANT_FIELD_BITS-1:0] ant_ff,  ant_in;
   logic                                has_ff,  has_in;
   logic                                eos_ff,  eos_in;
   logic [TAG_BITS-1:0]                 tag_ff,  tag_in;
   logic                                oldb_ff, oldb_in;
   logic [CW-1:0]                       oc_ff,   oc_in;
   logic [CW-1:0]                       nc_ff,   nc_in;
   logic [CW-1:0]                       rd_idx_ff, rd_idx_in;
   logic [CW-1:0]                       lv_idx_ff, lv_idx_in;
   logic                                found_ff,  found_in;
   logic                                cmp_valid_ff, cmp_valid_in;
   logic [IW-1:0]                       cmp_idx_ff,   cmp_idx_in;

   logic [NUM_ANTENNAS-1:0]             bank_sel_ff, bank_sel_in;
   logic [CW-1:0]                       count_ff [NUM_ANTENNAS][2];
   logic [CW-1:0]                       count_in [NUM_ANTENNAS][2];
   logic [MAX_TAGS-1:0]                 seen_ff, seen_in;
   logic                                overflow_ff, overflow_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   tpct_pkg::rsp_payload_type           rsp_data_ff,  rsp_data_in;

   logic [AW-1:0]       req_ant_idx;
   logic [AW-1:0]       ant_idx;
   logic                req_bank;
   logic                ram_wr_en;
   logic [RAW-1:0]      ram_wr_addr;
   logic                ram_rd_en;
   logic [RAW-1:0]      ram_rd_addr;
   logic [TAG_BITS-1:0] ram_rd_data;
   logic                search_more;
   logic                out_free;
   logic [MAX_TAGS-1:0] unseen;
   logic [MAX_TAGS-1:0] unseen_later;

   assign req_ant_idx = AW'(req_data.antenna);
   assign ant_idx     = AW'(ant_ff);
   assign req_bank    = bank_sel_ff[req_ant_idx];
   assign search_more = (rd_idx_ff < oc_ff);
   assign out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      for (int i = 0; i < MAX_TAGS; i++) begin
         unseen[i]       = !seen_ff[i] && (CW'(i) < oc_ff);
         unseen_later[i] = unseen[i] && (CW'(i) > lv_idx_ff);
      end
   end

   always_comb begin
      status.drop        = (int'(req_data.antenna) >= NUM_ANTENNAS) ||
                           (!req_data.has_tag && !req_data.end_of_scan);
      status.has_tag     = has_ff;
      status.end_of_scan = eos_ff;
      status.search_done = !search_more && !cmp_valid_ff;
      status.found       = found_ff;
      status.out_free    = out_free;
      status.leave_done  = !(lv_idx_ff < oc_ff);
      status.leave_seen  = seen_ff[lv_idx_ff[IW-1:0]];
   end

   assign ram_wr_en   = cmd.store && has_ff && (nc_ff < CW'(MAX_TAGS));
   assign ram_wr_addr = {ant_idx, ~oldb_ff, nc_ff[IW-1:0]};
   assign ram_rd_en   = (cmd.search && search_more) || cmd.leave_read;
   assign ram_rd_addr = cmd.leave_read ? {ant_idx, oldb_ff, lv_idx_ff[IW-1:0]}
                                       : {ant_idx, oldb_ff, rd_idx_ff[IW-1:0]};

   tpct_ram #(
      .WIDTH (TAG_BITS),
      .DEPTH (DEPTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (tag_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      ant_in       = ant_ff;
      has_in       = has_ff;
      eos_in       = eos_ff;
      tag_in       = tag_ff;
      oldb_in      = oldb_ff;
      oc_in        = oc_ff;
      nc_in        = nc_ff;
      rd_idx_in    = rd_idx_ff;
      lv_idx_in    = lv_idx_ff;
      found_in     = found_ff;
      cmp_valid_in = cmd.search && search_more;
      cmp_idx_in   = rd_idx_ff[IW-1:0];
      bank_sel_in  = bank_sel_ff;
      count_in     = count_ff;
      seen_in      = seen_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         ant_in    = req_data.antenna;
         has_in    = req_data.has_tag;
         eos_in    = req_data.end_of_scan;
         tag_in    = req_data.tag[TAG_BITS-1:0];
         oldb_in   = req_bank;
         oc_in     = count_ff[req_ant_idx][req_bank];
         nc_in     = count_ff[req_ant_idx][~req_bank];
         rd_idx_in = '0;
         lv_idx_in = '0;
         found_in  = 1'b0;
      end

      if (cmd.store && has_ff) begin
         if (nc_ff < CW'(MAX_TAGS)) begin
            count_in[ant_idx][~oldb_ff] = nc_ff + CW'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end

      if (cmd.search && search_more) begin
         rd_idx_in = rd_idx_ff + CW'(1);
      end

      if (cmp_valid_ff && (ram_rd_data == tag_ff)) begin
         found_in            = 1'b1;
         seen_in[cmp_idx_ff] = 1'b1;
      end

      if (cmd.leave_skip || cmd.emit_leave) begin
         lv_idx_in = lv_idx_ff + CW'(1);
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.emit_enter) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.antenna_out = ant_ff;
         rsp_data_in.tag_out     = tpct_pkg::TAG_FIELD_BITS'(tag_ff);
         rsp_data_in.event_res   = tpct_pkg::EVENT_ENTER;
         rsp_data_in.overflow    = overflow_ff;
         rsp_data_in.last        = !(eos_ff && (|unseen));
      end

      if (cmd.emit_leave) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.antenna_out = ant_ff;
         rsp_data_in.tag_out     = tpct_pkg::TAG_FIELD_BITS'(ram_rd_data);
         rsp_data_in.event_res   = tpct_pkg::EVENT_LEAVE;
         rsp_data_in.overflow    = overflow_ff;
         rsp_data_in.last        = !(|unseen_later);
      end

      if (cmd.finish) begin
         bank_sel_in[ant_idx]       = ~oldb_ff;
         count_in[ant_idx][oldb_ff] = '0;
         seen_in                    = '0;
         overflow_in                = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      ant_ff      <= ant_in;
      has_ff      <= has_in;
      eos_ff      <= eos_in;
      tag_ff      <= tag_in;
      oldb_ff     <= oldb_in;
      oc_ff       <= oc_in;
      nc_ff       <= nc_in;
      rd_idx_ff   <= rd_idx_in;
      lv_idx_ff   <= lv_idx_in;
      found_ff    <= found_in;
      cmp_idx_ff  <= cmp_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
         bank_sel_ff  <= '0;
         seen_ff      <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < NUM_ANTENNAS; a++) begin
            count_ff[a][0] <= '0;
            count_ff[a][1] <= '0;
         end
      end else begin
         cmp_valid_ff <= cmp_valid_in;
         bank_sel_ff  <= bank_sel_in;
         seen_ff      <= seen_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: verif/tag_presence_change_tracker_test.sv
// ----------------------------------------------------------------------------
// tag_presence_change_tracker_test
// Self-checking bench for the tag presence change tracker. A queue of tag
// reports feeds a clocked driver. Directed scans come first, then random
// scans drawn from small per-antenna tag pools, some of them past capacity,
// mixed with stray and ignored reports. A scoreboard model predicts every
// enter and leave event, and a clocked monitor checks the events field by
// field. Both sides stall in random bursts until the run nears its end.
// ----------------------------------------------------------------------------
module tag_presence_change_tracker_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_ANTENNAS   = 4;
   localparam int MAX_TAGS       = 32;
   localparam int TAG_BITS       = 64;
   localparam int POOL_SIZE      = 8;
   localparam int RANDOM_REPORTS = 500;
   localparam int CALM_REPORTS   = 50;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 3 * MAX_TAGS + 16;

   localparam logic [tpct_pkg::TAG_FIELD_BITS-1:0] TAG_MASK =
      {tpct_pkg::TAG_FIELD_BITS{1'b1}} >> (tpct_pkg::TAG_FIELD_BITS - TAG_BITS);
   localparam logic [tpct_pkg::TAG_FIELD_BITS-1:0] TAG_ZERO = '0;
   localparam logic [tpct_pkg::TAG_FIELD_BITS-1:0] TAG_ONES = '1;
   localparam logic [tpct_pkg::TAG_FIELD_BITS-1:0] TAG_A    = 64'h0123_4567_89AB_CDEF;
   localparam logic [tpct_pkg::TAG_FIELD_BITS-1:0] TAG_B    = 64'hFEDC_BA98_7654_3210;

   logic clock;
   logic reset;

   tpct_req_if req_bus ();
   tpct_rsp_if rsp_bus ();

   tag_presence_change_tracker #(
      .NUM_ANTENNAS (NUM_ANTENNAS),
      .MAX_TAGS     (MAX_TAGS),
      .TAG_BITS     (TAG_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   tpct_pkg::req_payload_type report_q [$];
   tpct_pkg::rsp_payload_type events_pending [$];

   logic [tpct_pkg::TAG_FIELD_BITS-1:0] scan_tags [NUM_ANTENNAS][2][MAX_TAGS];
   int unsigned                         scan_size [NUM_ANTENNAS][2];
   bit                                  prev_bank [NUM_ANTENNAS];
   bit                                  tag_seen  [MAX_TAGS];
   bit                                  scan_dropped;

   logic [tpct_pkg::TAG_FIELD_BITS-1:0] tag_pool [NUM_ANTENNAS][POOL_SIZE];

   int unsigned req_hold      = 0;
   int unsigned rsp_hold      = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned reports_taken = 0;
   int unsigned total_reports = 0;
   int unsigned directed_size = 0;
   int unsigned enters_seen   = 0;
   int unsigned leaves_seen   = 0;
   int unsigned overflow_seen = 0;
   int unsigned error_count   = 0;

   function automatic bit in_calm_phase();
      return report_q.size() < CALM_REPORTS;
   endfunction

   function automatic logic [tpct_pkg::TAG_FIELD_BITS-1:0] random_tag();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [tpct_pkg::TAG_FIELD_BITS-1:0] pick_tag(int unsigned ant);
      logic [tpct_pkg::TAG_FIELD_BITS-1:0] t;
      if ($urandom_range(0, 3) == 0) begin
         t = random_tag();
         if ($urandom_range(0, 1) == 1)
            tag_pool[ant][$urandom_range(0, POOL_SIZE - 1)] = t;
      end else begin
         t = tag_pool[ant][$urandom_range(0, POOL_SIZE - 1)];
      end
      return t;
   endfunction

   task automatic add_report(int unsigned ant, bit has,
                             logic [tpct_pkg::TAG_FIELD_BITS-1:0] t, bit eos);
      tpct_pkg::req_payload_type r;
      r.antenna     = ant[tpct_pkg::ANT_FIELD_BITS-1:0];
      r.has_tag     = has;
      r.tag         = t;
      r.end_of_scan = eos;
      report_q.push_back(r);
   endtask

   function automatic void push_event(int unsigned ant,
                                      logic [tpct_pkg::TAG_FIELD_BITS-1:0] t, logic ev);
      tpct_pkg::rsp_payload_type e;
      e.antenna_out = ant[tpct_pkg::ANT_FIELD_BITS-1:0];
      e.tag_out     = t & TAG_MASK;
      e.event_res   = ev;
      e.overflow    = scan_dropped;
      e.last        = 1'b0;
      events_pending.push_back(e);
   endfunction

   function automatic void predict_events(tpct_pkg::req_payload_type r);
      int unsigned                         ant;
      int unsigned                         old_b;
      int unsigned                         new_b;
      int unsigned                         old_n;
      int unsigned                         new_n;
      int unsigned                         produced;
      int unsigned                         i;
      bit                                  found;
      logic [tpct_pkg::TAG_FIELD_BITS-1:0] t;
      tpct_pkg::rsp_payload_type           tail;
      ant      = 32'(r.antenna);
      t        = r.tag & TAG_MASK;
      produced = 0;
      found    = 1'b0;
      if (ant >= NUM_ANTENNAS)
         return;
      if (!r.has_tag && !r.end_of_scan)
         return;
      old_b = 32'(prev_bank[ant]);
      new_b = old_b ^ 1;
      old_n = scan_size[ant][old_b];
      if (old_n > MAX_TAGS)
         old_n = MAX_TAGS;
      if (r.has_tag) begin
         for (i = 0; i < old_n; i++) begin
            if (scan_tags[ant][old_b][i] == t) begin
               found       = 1'b1;
               tag_seen[i] = 1'b1;
            end
         end
         new_n = scan_size[ant][new_b];
         if (new_n < MAX_TAGS) begin
            scan_tags[ant][new_b][new_n] = t;
            scan_size[ant][new_b]        = new_n + 1;
         end else begin
            scan_dropped = 1'b1;
         end
         if (!found) begin
            push_event(ant, t, tpct_pkg::EVENT_ENTER);
            produced++;
         end
      end
      if (r.end_of_scan) begin
         for (i = 0; i < old_n; i++) begin
            if (!tag_seen[i]) begin
               push_event(ant, scan_tags[ant][old_b][i], tpct_pkg::EVENT_LEAVE);
               produced++;
            end
         end
         prev_bank[ant]        = new_b[0];
         scan_size[ant][old_b] = 0;
         for (i = 0; i < MAX_TAGS; i++)
            tag_seen[i] = 1'b0;
         scan_dropped = 1'b0;
      end
      if (produced > 0) begin
         tail      = events_pending.pop_back();
         tail.last = 1'b1;
         events_pending.push_back(tail);
      end
   endfunction

   function automatic void check_field(string field,
                                       logic [tpct_pkg::TAG_FIELD_BITS-1:0] want,
                                       logic [tpct_pkg::TAG_FIELD_BITS-1:0] got);
      if (want !== got) begin
         error_count++;
         $error("%s mismatch: expected %h, actual %h", field, want, got);
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      tpct_pkg::req_payload_type taken;
      tpct_pkg::req_payload_type next_report;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_hold = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            taken = {req_bus.antenna, req_bus.has_tag, req_bus.tag, req_bus.end_of_scan};
            predict_events(taken);
            reports_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_hold > 0) begin
               req_hold--;
               req_bus.valid <= 1'b0;
            end else if (report_q.size() > 0) begin
               next_report = report_q.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.antenna     <= next_report.antenna;
               req_bus.has_tag     <= next_report.has_tag;
               req_bus.tag         <= next_report.tag;
               req_bus.end_of_scan <= next_report.end_of_scan;
               if (!in_calm_phase() && $urandom_range(0, 3) == 0)
                  req_hold = $urandom_range(1, 6);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      tpct_pkg::rsp_payload_type got;
      tpct_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.antenna_out, rsp_bus.tag_out, rsp_bus.event_res,
                   rsp_bus.overflow, rsp_bus.last};
            if (events_pending.size() == 0) begin
               error_count++;
               $error("event with none pending: antenna %0d, tag %h, event %0d",
                      got.antenna_out, got.tag_out, got.event_res);
            end else begin
               want = events_pending.pop_front();
               check_field("antenna_out", tpct_pkg::TAG_FIELD_BITS'(want.antenna_out),
                           tpct_pkg::TAG_FIELD_BITS'(got.antenna_out));
               check_field("tag_out", want.tag_out, got.tag_out);
               check_field("event_res", tpct_pkg::TAG_FIELD_BITS'(want.event_res),
                           tpct_pkg::TAG_FIELD_BITS'(got.event_res));
               check_field("overflow", tpct_pkg::TAG_FIELD_BITS'(want.overflow),
                           tpct_pkg::TAG_FIELD_BITS'(got.overflow));
               check_field("last", tpct_pkg::TAG_FIELD_BITS'(want.last),
                           tpct_pkg::TAG_FIELD_BITS'(got.last));
               if (want.event_res == tpct_pkg::EVENT_LEAVE)
                  leaves_seen++;
               else
                  enters_seen++;
               if (want.overflow)
                  overflow_seen++;
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!in_calm_phase() && $urandom_range(0, 4) == 0)
               rsp_hold = $urandom_range(1, 6);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      int unsigned a;
      int unsigned b;
      int unsigned k;
      int unsigned pick;
      int unsigned scan_len;
      int unsigned counted;
      bit          bare_end;

      req_bus.valid       = 1'b0;
      req_bus.antenna     = '0;
      req_bus.has_tag     = 1'b0;
      req_bus.tag         = '0;
      req_bus.end_of_scan = 1'b0;
      rsp_bus.ready       = 1'b0;
      reset               = 1'b1;

      for (a = 0; a < NUM_ANTENNAS; a++) begin
         prev_bank[a] = 1'b0;
         for (b = 0; b < 2; b++)
            scan_size[a][b] = 0;
         for (k = 0; k < POOL_SIZE; k++)
            tag_pool[a][k] = random_tag();
      end
      for (k = 0; k < MAX_TAGS; k++)
         tag_seen[k] = 1'b0;
      scan_dropped = 1'b0;

      // ignored report, then a first scan with a duplicate
      add_report(0, 0, TAG_ONES, 0);
      add_report(0, 1, TAG_ZERO, 0);
      add_report(0, 1, TAG_ONES, 0);
      add_report(0, 1, TAG_A, 0);
      add_report(0, 1, TAG_ONES, 1);
      // second scan closed by a bare end marker
      add_report(0, 1, TAG_A, 0);
      add_report(0, 1, TAG_B, 0);
      add_report(0, 0, TAG_ZERO, 1);
      // empty first scan, then a one-report scan
      add_report(1, 0, TAG_ONES, 1);
      add_report(3, 1, TAG_A, 1);
      // interleave antennas through the shared seen marks
      add_report(0, 1, TAG_A, 0);
      add_report(3, 0, TAG_ZERO, 1);
      add_report(0, 1, TAG_B, 1);
      add_report(2, 1, TAG_ONES, 0);
      add_report(2, 1, TAG_ZERO, 1);
      add_report(2, 1, TAG_ZERO, 0);
      add_report(2, 0, TAG_ONES, 0);
      add_report(2, 1, TAG_ONES, 1);
      add_report(1, 1, TAG_B, 1);
      directed_size = report_q.size();

      counted = 0;
      while (counted < RANDOM_REPORTS) begin
         pick = $urandom_range(0, 9);
         a    = $urandom_range(0, NUM_ANTENNAS - 1);
         if (pick == 0) begin
            add_report(a, 0, random_tag(), 0);
         end else if (pick == 1) begin
            add_report(a, 1, pick_tag(a), 0);
            counted++;
         end else begin
            if ($urandom_range(0, 9) == 0)
               scan_len = $urandom_range(MAX_TAGS - 2, MAX_TAGS + 4);
            else
               scan_len = $urandom_range(0, 6);
            bare_end = (scan_len == 0) || ($urandom_range(0, 3) == 0);
            for (k = 0; k < scan_len; k++)
               add_report(a, 1, pick_tag(a), !bare_end && (k == scan_len - 1));
            if (bare_end)
               add_report(a, 0, random_tag(), 1);
            counted += scan_len + 32'(bare_end);
         end
      end
      total_reports = report_q.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      fork
         begin
            while (reports_taken < total_reports || events_pending.size() != 0)
               @(posedge clock);
            repeat (DRAIN_CYCLES) @(posedge clock);
         end
         while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clock);
      join_any

      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         error_count++;
         $error("watchdog expired after %0d idle cycles", quiet_cycles);
      end
      if (events_pending.size() != 0) begin
         error_count++;
         $error("%0d expected events never arrived", events_pending.size());
      end

      $display("Run covered %0d of %0d reports (%0d directed) over four antennas.",
               reports_taken, total_reports, directed_size);
      $display("Checked %0d enter and %0d leave events, %0d of them flagged overflow.",
               enters_seen, leaves_seen, overflow_seen);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: files.f
sv/tpct_pkg.sv
sv/tpct_req_if.sv
sv/tpct_rsp_if.sv
sv/tpct_ram.sv
sv/tpct_ctrl.sv
sv/tpct_dp.sv
sv/tag_presence_change_tracker.sv
verif/tag_presence_change_tracker_test.sv
